FILE: design/phlr_pkg.sv
`timescale 1ns / 1ps

package phlr_pkg;

	// bytes covered by the hash
	localparam int unsigned POOL_BYTES = 256;
	// bytes reachable by the write index (index is 6 bits)
	localparam int unsigned IDX_W      = 6;
	localparam int unsigned MEM_DEPTH  = 1 << IDX_W;
	localparam int unsigned CNT_W      = $clog2(POOL_BYTES);

	localparam logic [31:0] HASH_PRIME = 32'd16777619;
	localparam logic [31:0] MIX_MUL    = 32'h41c6_4e6d;
	localparam logic [31:0] MIX_ADD    = 32'h0000_3039;

	localparam logic MODE_DRAW = 1'b0;
	localparam logic MODE_SEED = 1'b1;

	typedef struct packed {
		logic start;   // load hash basis, clear byte counter
		logic seed;    // load lcg state from seed_value
		logic step;    // read pool byte at counter, fold into hash next cycle
		logic mix;     // step the lcg
		logic write;   // update pool, index and output register
	} phlr_cmd_t;

	typedef struct packed {
		logic last;      // counter is on the final pool byte
		logic out_busy;  // result register holds a beat not yet taken
	} phlr_sts_t;

endpackage

FILE: design/phlr_ctrl.sv
`timescale 1ns / 1ps

module phlr_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tuser,
	output logic              s_tready,
	input  phlr_pkg::phlr_sts_t sts,
	output phlr_pkg::phlr_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_HASH,
		ST_MIX,
		ST_WRITE
	} state_t;

	state_t state_q;
	logic   accept;

	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		cmd        = '0;
		cmd.start  = accept && (s_tuser == phlr_pkg::MODE_DRAW);
		cmd.seed   = accept && (s_tuser == phlr_pkg::MODE_SEED);
		cmd.step   = (state_q == ST_HASH);
		cmd.mix    = (state_q == ST_MIX);
		cmd.write  = (state_q == ST_WRITE) && !sts.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept && (s_tuser == phlr_pkg::MODE_DRAW)) begin
						state_q <= ST_HASH;
					end
				end
				ST_HASH: begin
					if (sts.last) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					state_q <= ST_WRITE;
				end
				ST_WRITE: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

FILE: design/phlr_dp.sv
`timescale 1ns / 1ps

module phlr_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  phlr_pkg::phlr_cmd_t cmd,
	output phlr_pkg::phlr_sts_t sts,
	input  logic [31:0]         entropy,
	input  logic [31:0]         seed_value,
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [31:0]         m_tdata
);

	logic [7:0]                   mem [phlr_pkg::MEM_DEPTH];
	logic [phlr_pkg::MEM_DEPTH-1:0] vld_q;

	logic [phlr_pkg::CNT_W-1:0] cnt_q;
	logic [phlr_pkg::IDX_W-1:0] widx_q;
	logic [31:0]                hash_q;
	logic [31:0]                ent_q;
	logic [31:0]                lcg_q;
	logic [31:0]                word_q;
	logic                       out_vld_q;

	logic [phlr_pkg::IDX_W-1:0] rd_addr;
	logic                       rd_live;
	logic [7:0]                 rd_s1;
	logic                       zero_s1;
	logic                       step_s1;
	logic [7:0]                 byte_s1;
	logic [31:0]                lcg_base;
	logic [31:0]                word;

	// bytes beyond the writable window and never-written bytes read as zero
	assign rd_addr = cmd.step ? cnt_q[phlr_pkg::IDX_W-1:0] : widx_q;
	assign rd_live = cmd.step
		? ((cnt_q >> phlr_pkg::IDX_W) == '0) && vld_q[rd_addr]
		: vld_q[rd_addr];
	assign byte_s1  = zero_s1 ? 8'h00 : rd_s1;
	assign lcg_base = (lcg_q == 32'd0) ? ent_q : lcg_q;
	assign word     = hash_q ^ lcg_q;

	assign sts.last     = (cnt_q == phlr_pkg::CNT_W'(phlr_pkg::POOL_BYTES - 1));
	assign sts.out_busy = out_vld_q && !m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = word_q;

	always_ff @(posedge clk) begin
		rd_s1 <= mem[rd_addr];
		if (cmd.write) begin
			mem[widx_q] <= byte_s1 ^ word[7:0];
		end
	end

	always_ff @(posedge clk) begin
		zero_s1 <= !rd_live;
		if (cmd.start) begin
			hash_q <= entropy;
			ent_q  <= entropy;
		end else if (step_s1) begin
			hash_q <= (hash_q ^ {24'd0, byte_s1}) * phlr_pkg::HASH_PRIME;
		end
		if (cmd.write) begin
			word_q <= word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q     <= '0;
			cnt_q     <= '0;
			widx_q    <= '0;
			lcg_q     <= '0;
			step_s1   <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			step_s1 <= cmd.step;
			if (cmd.start) begin
				cnt_q <= '0;
			end else if (cmd.step) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.seed) begin
				lcg_q <= seed_value;
			end else if (cmd.mix) begin
				lcg_q <= lcg_base * phlr_pkg::MIX_MUL + phlr_pkg::MIX_ADD;
			end
			if (cmd.write) begin
				vld_q[widx_q] <= 1'b1;
				widx_q        <= word[phlr_pkg::IDX_W-1:0];
				out_vld_q     <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

FILE: design/pooled_hash_lcg_random_core.sv
`timescale 1ns / 1ps

// Random-word generator: FNV-1a hash over a byte pool, XORed with an LCG.
// Input channel s_*: tuser is the request kind (0 draw, 1 seed load);
// tdata carries entropy and seed_value. Output channel m_*: one 32-bit
// random word per draw, none per seed load.
// A seed load does not leave the idle state, so s_tready stays high.
// A draw first folds the pool bytes into the hash (one dependent multiply
// per byte, one pool read per cycle), then steps the LCG and reads the
// byte at the write index, then updates that byte and loads the result.
// s_tready is high only while no draw is in progress, so the next request
// is taken the cycle after the result loads.
// The result sits in an output register; a new request is accepted while
// it waits. If the receiver still stalls when the next draw finishes, the
// block holds in its last cycle until the register frees.
// Reset clears the LCG state, the write index and the pool (through per-byte
// valid bits, no clearing pass), and drops m_tvalid.
module pooled_hash_lcg_random_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] entropy, [63:32] seed_value
	input  logic        s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [31:0] random_word
);

	phlr_pkg::phlr_cmd_t cmd;
	phlr_pkg::phlr_sts_t sts;

	phlr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	phlr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.entropy    (s_tdata[31:0]),
		.seed_value (s_tdata[63:32]),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

FILE: tb/phlr_word_checker.sv
`timescale 1ns / 1ps

module phlr_word_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [63:0] s_tdata,   // [31:0] entropy, [63:32] seed_value
	input  logic        s_tuser,   // [0] mode
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // [31:0] random_word
	output int          fail_count,
	output int          pending
);

	logic [7:0]                 pool_m [phlr_pkg::POOL_BYTES];
	logic [31:0]                lcg_m;
	logic [phlr_pkg::IDX_W-1:0] idx_m;
	logic [31:0]                word_q [$];

	function automatic logic [31:0] fnv_pool_hash(input logic [31:0] basis);
		logic [31:0] h;
		h = basis;
		for (int i = 0; i < phlr_pkg::POOL_BYTES; i++) begin
			h = (h ^ {24'd0, pool_m[i]}) * phlr_pkg::HASH_PRIME;
		end
		return h;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		logic [31:0] h;
		logic [31:0] st;
		logic [31:0] word;
		logic [31:0] want;
		if (!arst_n) begin
			for (int i = 0; i < phlr_pkg::POOL_BYTES; i++) begin
				pool_m[i] = 8'd0;
			end
			lcg_m = '0;
			idx_m = '0;
			word_q.delete();
			fail_count = 0;
			pending = 0;
		end else begin
			// result beat first: it always belongs to an earlier draw
			if (m_tvalid && m_tready) begin
				if (word_q.size() == 0) begin
					$display("%0t: unexpected random_word beat: expected none, actual %08h",
						$time, m_tdata);
					fail_count++;
				end else begin
					want = word_q.pop_front();
					if (m_tdata !== want) begin
						$display("%0t: random_word mismatch: expected %08h, actual %08h",
							$time, want, m_tdata);
						fail_count++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				if (s_tuser == phlr_pkg::MODE_SEED) begin
					lcg_m = s_tdata[63:32];
				end else begin
					h = fnv_pool_hash(s_tdata[31:0]);
					// zero state takes the entropy word as seed
					st = (lcg_m == 32'd0) ? s_tdata[31:0] : lcg_m;
					st = st * phlr_pkg::MIX_MUL + phlr_pkg::MIX_ADD;
					lcg_m = st;
					word = h ^ st;
					pool_m[idx_m] = pool_m[idx_m] ^ word[7:0];
					idx_m = word[phlr_pkg::IDX_W-1:0];
					word_q.push_back(word);
				end
			end
			pending = word_q.size();
		end
	end

endmodule

FILE: tb/pooled_hash_lcg_random_core_tb.sv
`timescale 1ns / 1ps

module pooled_hash_lcg_random_core_tb;

	localparam int CYCLE_LIMIT  = 5_000_000;
	localparam int RANDOM_ITEMS = 600;
	localparam int DRAIN_CYCLES = 300;

	bit          clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;

	int fail_count;
	int pending;
	int cycles    = 0;
	int hold_left = 0;
	bit quiet     = 1'b0;

	always #2 clk = ~clk;

	pooled_hash_lcg_random_core i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	phlr_word_checker i_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	// receiver: short random stalls, now and then a long one so that a
	// finished draw has to wait for the output register
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready  <= 1'b0;
		end else if (!quiet && $urandom_range(0, 2999) == 0) begin
			hold_left <= $urandom_range(250, 600);
			m_tready  <= 1'b0;
		end else begin
			m_tready <= quiet || ($urandom_range(0, 99) >= 10);
		end
	end

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_req(input logic mode, input logic [31:0] ent,
		input logic [31:0] seedv);
		while (!quiet && $urandom_range(0, 99) < 10) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {seedv, ent};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	initial begin
		int pick;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tuser  = phlr_pkg::MODE_DRAW;
		s_tdata  = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// zero state and zero entropy
		send_req(phlr_pkg::MODE_DRAW, 32'h0000_0000, 32'hffff_ffff);
		send_req(phlr_pkg::MODE_DRAW, 32'hffff_ffff, 32'hffff_ffff);
		// zero seed: next draw takes its entropy word
		send_req(phlr_pkg::MODE_SEED, 32'hffff_ffff, 32'h0000_0000);
		send_req(phlr_pkg::MODE_DRAW, 32'h1234_5678, 32'h0000_0000);
		send_req(phlr_pkg::MODE_SEED, 32'h0000_0000, 32'hffff_ffff);
		send_req(phlr_pkg::MODE_DRAW, 32'h0000_0000, 32'h0000_0000);
		send_req(phlr_pkg::MODE_SEED, 32'h5555_5555, 32'h0000_0001);
		send_req(phlr_pkg::MODE_DRAW, 32'hffff_ffff, 32'haaaa_aaaa);
		send_req(phlr_pkg::MODE_SEED, 32'h0000_0000, 32'h8000_0000);
		send_req(phlr_pkg::MODE_DRAW, 32'h8000_0000, 32'h5555_5555);
		// zero seed with zero entropy again
		send_req(phlr_pkg::MODE_SEED, 32'h0000_0000, 32'h0000_0000);
		send_req(phlr_pkg::MODE_DRAW, 32'h0000_0000, 32'h0000_0000);
		// back-to-back seed loads, last one wins
		send_req(phlr_pkg::MODE_SEED, 32'haaaa_aaaa, 32'hdead_beef);
		send_req(phlr_pkg::MODE_SEED, 32'h5555_5555, 32'h7fff_ffff);
		send_req(phlr_pkg::MODE_DRAW, 32'haaaa_aaaa, 32'h5555_5555);
		send_req(phlr_pkg::MODE_DRAW, 32'h5555_5555, 32'haaaa_aaaa);
		send_req(phlr_pkg::MODE_DRAW, 32'h7fff_ffff, 32'h8000_0000);
		send_req(phlr_pkg::MODE_DRAW, $urandom, $urandom);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			quiet = (n >= 250 && n < 400);
			pick  = $urandom_range(0, 99);
			if (pick < 6)
				send_req(phlr_pkg::MODE_SEED, $urandom, 32'd0);
			else if (pick < 20)
				send_req(phlr_pkg::MODE_SEED, $urandom, $urandom);
			else if (pick < 25)
				send_req(phlr_pkg::MODE_DRAW, 32'd0, $urandom);
			else
				send_req(phlr_pkg::MODE_DRAW, $urandom, $urandom);
		end
		s_tvalid <= 1'b0;
		quiet = 1'b0;

		while (pending != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fail_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

FILE: sim.f
design/phlr_pkg.sv
design/phlr_ctrl.sv
design/phlr_dp.sv
design/pooled_hash_lcg_random_core.sv
tb/phlr_word_checker.sv
tb/pooled_hash_lcg_random_core_tb.sv
